FILE: rtl/core/lpc_pkg.sv
// lpc_pkg: shared constants and code tables for the lattice speech synthesizer
// depends on nothing
`timescale 1ns / 1ps
package lpc_pkg;
  localparam int CHIRP_LEN_DEF = 41;
  localparam int CHIRP_STORED = 41;
  localparam logic [15:0] NOISE_TAPS = 16'hB800;
  localparam logic [15:0] OUT_OFFSET = 16'h0100;
  localparam logic [3:0] ECODE_SILENT = 4'd0;
  localparam logic [3:0] ECODE_STOP = 4'd15;
  localparam int NSTAGE = 10;

  function automatic logic [7:0] chirp_lut(input logic [5:0] i);
    logic [7:0] t [0:40];
    t = '{8'h00,8'h2A,8'hD4,8'h32,8'hB2,8'h12,8'h25,8'h14,8'h02,8'hE1,8'hC5,8'h02,
          8'h5F,8'h5A,8'h05,8'h0F,8'h26,8'hFC,8'hA5,8'hA5,8'hD6,8'hDD,8'hDC,8'hFC,
          8'h25,8'h2B,8'h22,8'h21,8'h0F,8'hFF,8'hF8,8'hEE,8'hED,8'hEF,8'hF7,8'hF6,
          8'hFA,8'h00,8'h03,8'h02,8'h01};
    return (i < 6'd41) ? t[i] : 8'h00;
  endfunction

  function automatic logic [7:0] energy_lut(input logic [3:0] i);
    logic [7:0] t [0:15];
    t = '{8'h00,8'h02,8'h03,8'h04,8'h05,8'h07,8'h0A,8'h0F,
          8'h14,8'h20,8'h29,8'h39,8'h51,8'h72,8'hA1,8'hFF};
    return t[i];
  endfunction

  function automatic logic [7:0] pitch_lut(input logic [5:0] i);
    logic [7:0] t [0:63];
    t = '{8'h00,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1A,
          8'h1B,8'h1C,8'h1D,8'h1E,8'h1F,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,
          8'h27,8'h28,8'h29,8'h2A,8'h2B,8'h2D,8'h2F,8'h31,8'h33,8'h35,8'h36,8'h39,
          8'h3B,8'h3D,8'h3F,8'h42,8'h45,8'h47,8'h49,8'h4D,8'h4F,8'h51,8'h55,8'h57,
          8'h5C,8'h5F,8'h63,8'h66,8'h6A,8'h6E,8'h73,8'h77,8'h7B,8'h80,8'h85,8'h8A,
          8'h8F,8'h95,8'h9A,8'hA0};
    return t[i];
  endfunction

  function automatic logic [15:0] k1_lut(input logic [4:0] i);
    logic [15:0] t [0:31];
    t = '{16'h82C0,16'h8380,16'h83C0,16'h8440,16'h84C0,16'h8540,16'h8600,16'h8780,
          16'h8880,16'h8980,16'h8AC0,16'h8C00,16'h8D40,16'h8F00,16'h90C0,16'h92C0,
          16'h9900,16'hA140,16'hAB80,16'hB840,16'hC740,16'hD8C0,16'hEBC0,16'h0000,
          16'h1440,16'h2740,16'h38C0,16'h47C0,16'h5480,16'h5EC0,16'h6700,16'h6D40};
    return t[i];
  endfunction

  function automatic logic [15:0] k2_lut(input logic [4:0] i);
    logic [15:0] t [0:31];
    t = '{16'hAE00,16'hB480,16'hBB80,16'hC340,16'hCB80,16'hD440,16'hDDC0,16'hE780,
          16'hF180,16'hFBC0,16'h0600,16'h1040,16'h1A40,16'h2400,16'h2D40,16'h3600,
          16'h3E40,16'h45C0,16'h4CC0,16'h5300,16'h5880,16'h5DC0,16'h6240,16'h6640,
          16'h69C0,16'h6CC0,16'h6F80,16'h71C0,16'h73C0,16'h7580,16'h7700,16'h7E80};
    return t[i];
  endfunction

  // narrow coefficient tables, selected by coefficient slot (0 = k3 .. 7 = k10)
  function automatic logic [7:0] kn_lut(input logic [2:0] slot, input logic [3:0] i);
    logic [7:0] t3 [0:15];
    logic [7:0] t4 [0:15];
    logic [7:0] t5 [0:15];
    logic [7:0] t6 [0:15];
    logic [7:0] t7 [0:15];
    logic [7:0] t8 [0:7];
    logic [7:0] t9 [0:7];
    logic [7:0] t10 [0:7];
    logic [7:0] r;
    t3 = '{8'h92,8'h9F,8'hAD,8'hBA,8'hC8,8'hD5,8'hE3,8'hF0,
           8'hFE,8'h0B,8'h19,8'h26,8'h34,8'h41,8'h4F,8'h5C};
    t4 = '{8'hAE,8'hBC,8'hCA,8'hD8,8'hE6,8'hF4,8'h01,8'h0F,
           8'h1D,8'h2B,8'h39,8'h47,8'h55,8'h63,8'h71,8'h7E};
    t5 = '{8'hAE,8'hBA,8'hC5,8'hD1,8'hDD,8'hE8,8'hF4,8'hFF,
           8'h0B,8'h17,8'h22,8'h2E,8'h39,8'h45,8'h51,8'h5C};
    t6 = '{8'hC0,8'hCB,8'hD6,8'hE1,8'hEC,8'hF7,8'h03,8'h0E,
           8'h19,8'h24,8'h2F,8'h3A,8'h45,8'h50,8'h5B,8'h66};
    t7 = '{8'hB3,8'hBF,8'hCB,8'hD7,8'hE3,8'hEF,8'hFB,8'h07,
           8'h13,8'h1F,8'h2B,8'h37,8'h43,8'h4F,8'h5A,8'h66};
    t8 = '{8'hC0,8'hD8,8'hF0,8'h07,8'h1F,8'h37,8'h4F,8'h66};
    t9 = '{8'hC0,8'hD4,8'hE8,8'hFC,8'h10,8'h25,8'h39,8'h4D};
    t10 = '{8'hCD,8'hDF,8'hF1,8'h04,8'h16,8'h20,8'h3B,8'h4D};
    case (slot)
      3'd0: r = t3[i];
      3'd1: r = t4[i];
      3'd2: r = t5[i];
      3'd3: r = t6[i];
      3'd4: r = t7[i];
      3'd5: r = t8[i[2:0]];
      3'd6: r = t9[i[2:0]];
      default: r = t10[i[2:0]];
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/core/lpc_mac.sv
// lpc_mac: registered lattice multiply and shift, add or subtract, 16-bit wrap
// depends on lpc_pkg
`timescale 1ns / 1ps
module lpc_mac (
  input  logic        clk,
  input  logic        start,
  input  logic [15:0] coef,
  input  logic        wide,
  input  logic [15:0] mul_in,
  input  logic [15:0] acc_in,
  input  logic        sub,
  output logic [15:0] result
);
  import lpc_pkg::*;
  logic signed [31:0] prod;
  logic signed [31:0] shifted;
  logic [15:0] acc_q;
  logic sub_q;
  logic wide_q;
  logic signed [16:0] cq;

  // narrow coefficients sit sign-held in the low byte
  assign cq = wide ? {coef[15], coef} : {{9{coef[7]}}, coef[7:0]};

  // product registered, then shift and add next cycle
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= 32'(cq * $signed(mul_in));
      acc_q <= acc_in;
      sub_q <= sub;
      wide_q <= wide;
    end
  end

  assign shifted = wide_q ? (prod >>> 15) : (prod >>> 7);
  assign result = sub_q ? (acc_q - shifted[15:0]) : (acc_q + shifted[15:0]);
endmodule

FILE: rtl/core/lpc10_speech_synth_unit.sv
// lpc10_speech_synth_unit: top level of the lattice speech synthesizer
// depends on lpc_pkg and lpc_mac
`timescale 1ns / 1ps
//  channel | direction | payload
//  in      | input     | func energy_code repeat_flag pitch_code low/high_coef_codes
//  out     | output    | sample_value
// a stop frame or a frame that loads coefficients is taken in the accept cycle,
// then the coefficient slots are visited one per cycle: a stop frame writes
// zeros, a voiced frame k1..k10, an unvoiced frame only k1..k4. silent and
// repeat frames end in the accept cycle. a tick item runs the excitation step,
// 10 forward and 9 reverse stages (memory read, registered multiply, write back)
// and a final step that registers the sample and raises out_valid.
// reset clears the registers at once; the coefficient and history memories
// are swept to zero in the clear state, during which no item is taken.
// while a result waits under a stalled output, no item is taken.
module lpc10_speech_synth_unit #(
  parameter int CHIRP_LEN = lpc_pkg::CHIRP_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [3:0]  energy_code,
  input  logic        repeat_flag,
  input  logic [5:0]  pitch_code,
  input  logic [17:0] low_coef_codes,
  input  logic [20:0] high_coef_codes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] sample_value
);
  import lpc_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FRAME, S_EXC, S_FRD, S_FMUL, S_FWB,
    S_RRD, S_RMUL, S_RWB, S_DONE
  } state_t;
  state_t state;

  // coefficient memory (k1..k10, 16 bits, narrow ones sign-held in low byte)
  logic [15:0] coef_mem [0:NSTAGE-1];
  // lattice history memory
  logic [15:0] hist_mem [0:NSTAGE-1];
  logic [15:0] coef_rd;
  logic [15:0] hist_rd;
  logic [3:0]  rd_addr;
  logic        cw_en, hw_en;
  logic [3:0]  cw_addr, hw_addr;
  logic [15:0] cw_data, hw_data;

  always_ff @(posedge clk) begin
    if (cw_en) coef_mem[cw_addr] <= cw_data;
    if (hw_en) hist_mem[hw_addr] <= hw_data;
    coef_rd <= coef_mem[rd_addr];
    hist_rd <= hist_mem[rd_addr];
  end

  logic [7:0]  cur_energy, cur_pitch, period_count;
  logic [15:0] noise_lfsr;
  logic [3:0]  idx;
  logic [15:0] u_acc;          // running forward value
  logic [15:0] u_save [0:NSTAGE-1]; // forward values per stage, fixed taps
  logic [17:0] lo_q;
  logic [20:0] hi_q;
  logic        voiced_q, load_coef;

  logic        mac_start;
  logic [15:0] mac_coef, mac_mul, mac_acc, mac_res;
  logic        mac_sub;

  // k1 and k2 are the wide coefficients; the read address names the stage
  lpc_mac u_mac (
    .clk(clk), .start(mac_start), .coef(mac_coef), .wide(rd_addr < 4'd2),
    .mul_in(mac_mul), .acc_in(mac_acc), .sub(mac_sub), .result(mac_res)
  );

  logic signed [15:0] chirp_prod;
  logic [7:0] pc_next;
  logic [15:0] lfsr_next;
  logic [15:0] exc;
  always_comb begin
    pc_next = (period_count < cur_pitch) ? period_count + 8'd1 : 8'd0;
    lfsr_next = (noise_lfsr >> 1) ^ (noise_lfsr[0] ? NOISE_TAPS : 16'h0000);
    chirp_prod = 16'(($signed(chirp_lut(pc_next[5:0])) * $signed({1'b0, cur_energy})) >>> 8);
    if (cur_pitch != 8'd0)
      exc = (32'(pc_next) < CHIRP_LEN && pc_next < 8'(CHIRP_STORED)) ? chirp_prod : 16'h0;
    else
      exc = lfsr_next[0] ? {8'h00, cur_energy} : -{8'h00, cur_energy};
  end

  // frame coefficient for current slot
  logic [15:0] frame_coef;
  always_comb begin
    case (idx)
      4'd0: frame_coef = k1_lut(lo_q[17:13]);
      4'd1: frame_coef = k2_lut(lo_q[12:8]);
      4'd2: frame_coef = {8'h00, kn_lut(3'd0, lo_q[7:4])};
      4'd3: frame_coef = {8'h00, kn_lut(3'd1, lo_q[3:0])};
      4'd4: frame_coef = {8'h00, kn_lut(3'd2, hi_q[20:17])};
      4'd5: frame_coef = {8'h00, kn_lut(3'd3, hi_q[16:13])};
      4'd6: frame_coef = {8'h00, kn_lut(3'd4, hi_q[12:9])};
      4'd7: frame_coef = {8'h00, kn_lut(3'd5, {1'b0, hi_q[8:6]})};
      4'd8: frame_coef = {8'h00, kn_lut(3'd6, {1'b0, hi_q[5:3]})};
      default: frame_coef = {8'h00, kn_lut(3'd7, {1'b0, hi_q[2:0]})};
    endcase
  end

  always_comb begin
    cw_en = 1'b0; cw_addr = idx; cw_data = 16'h0;
    hw_en = 1'b0; hw_addr = idx; hw_data = 16'h0;
    rd_addr = idx;
    mac_start = 1'b0; mac_coef = coef_rd; mac_mul = hist_rd; mac_acc = u_acc;
    mac_sub = 1'b1;
    case (state)
      S_CLR: begin
        cw_en = 1'b1; hw_en = 1'b1;
      end
      S_FRAME: begin
        // stop clears all; otherwise load k1..k4, and k5..k10 when voiced
        if (load_coef && (idx < 4'd4 || voiced_q)) begin
          cw_en = 1'b1; cw_data = frame_coef;
        end else if (!load_coef) begin
          cw_en = 1'b1;
        end
      end
      S_FMUL: mac_start = 1'b1;
      S_RMUL: begin
        // stage idx-1: x[idx-1] + k(idx-1) * u[idx-1]
        mac_start = 1'b1; mac_mul = u_save[idx - 4'd1];
        mac_acc = hist_rd; mac_sub = 1'b0;
      end
      S_RWB: begin
        hw_en = 1'b1; hw_data = mac_res;
      end
      S_RRD: rd_addr = idx - 4'd1;
      S_DONE: begin
        hw_en = 1'b1; hw_addr = 4'd0; hw_data = u_save[0];
      end
      default: ;
    endcase
    if (state == S_RMUL) rd_addr = idx - 4'd1;
  end

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; idx <= 4'd0;
      cur_energy <= 8'd0; cur_pitch <= 8'd0; period_count <= 8'd0;
      noise_lfsr <= 16'h0001; out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          idx <= idx + 4'd1;
          if (idx == 4'(NSTAGE - 1)) begin idx <= 4'd0; state <= S_IDLE; end
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            lo_q <= low_coef_codes; hi_q <= high_coef_codes;
            idx <= 4'd0;
            if (!func) begin
              if (energy_code == ECODE_SILENT) begin
                cur_energy <= 8'd0;
              end else if (energy_code == ECODE_STOP) begin
                cur_energy <= 8'd0; load_coef <= 1'b0; state <= S_FRAME;
              end else begin
                cur_energy <= energy_lut(energy_code);
                cur_pitch <= pitch_lut(pitch_code);
                voiced_q <= pitch_lut(pitch_code) != 8'd0;
                load_coef <= 1'b1;
                if (!repeat_flag) state <= S_FRAME;
              end
            end else begin
              state <= S_EXC;
            end
          end
        end
        S_FRAME: begin
          idx <= idx + 4'd1;
          if (idx == 4'(NSTAGE - 1)) state <= S_IDLE;
        end
        S_EXC: begin
          if (cur_pitch != 8'd0) period_count <= pc_next;
          else noise_lfsr <= lfsr_next;
          u_acc <= exc; idx <= 4'(NSTAGE - 1); state <= S_FRD;
        end
        S_FRD: state <= S_FMUL;         // memory read in flight
        S_FMUL: state <= S_FWB;
        S_FWB: begin
          u_acc <= mac_res; u_save[idx] <= mac_res;
          if (idx == 4'd0) begin idx <= 4'(NSTAGE - 1); state <= S_RRD; end
          else begin idx <= idx - 4'd1; state <= S_FRD; end
        end
        S_RRD: state <= S_RMUL;
        S_RMUL: state <= S_RWB;
        S_RWB: begin
          if (idx == 4'd1) state <= S_DONE;
          else begin idx <= idx - 4'd1; state <= S_RRD; end
        end
        S_DONE: begin
          sample_value <= u_save[0] + OUT_OFFSET;
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
